FILE: hw/rtl/lis_pkg.sv
// shared types and constants for the longest ideal subsequence block
package lis_pkg;

	localparam int LETTER_W = 5;
	localparam int GAP_W    = 5;
	localparam int OUT_W    = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} lis_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_issue;
		logic write_back;
		logic load_out;
	} lis_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic in_range;
		logic scan_last;
	} lis_status_t;

endpackage

FILE: hw/rtl/lis_datapath.sv
// table memory, window scan, running peak and best length registers
module lis_datapath #(
	parameter int ALPHABET_SIZE = 26,
	parameter int LENGTH_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lis_pkg::lis_cmd_t             cmd,
	output lis_pkg::lis_status_t          status,
	input  logic [lis_pkg::LETTER_W-1:0]  letter,
	input  logic                          start_new,
	input  logic                          cfg_we,
	input  logic [lis_pkg::GAP_W-1:0]     cfg_gap,
	output logic [lis_pkg::OUT_W-1:0]     best_length
);
	import lis_pkg::*;

	localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int CMP_W = ((LETTER_W > IDX_W) ? LETTER_W : IDX_W) + 1;
	localparam logic [CMP_W-1:0] LAST_IDX = CMP_W'(ALPHABET_SIZE - 1);

	logic [GAP_W-1:0]       gap_q;
	logic [IDX_W-1:0]       letter_q;
	logic [IDX_W-1:0]       addr_q;
	logic [IDX_W-1:0]       hi_q;
	logic [LENGTH_BITS-1:0] peak_q;
	logic [LENGTH_BITS-1:0] best_q;
	logic [OUT_W-1:0]       out_q;
	logic [ALPHABET_SIZE-1:0] valid_q;
	logic [LENGTH_BITS-1:0] mem_q [ALPHABET_SIZE];
	logic [LENGTH_BITS-1:0] rd_data_s1;
	logic                   rd_ok_s1;
	logic                   rd_pend_s1;

	logic [CMP_W-1:0]       letter_ext;
	logic [CMP_W-1:0]       gap_ext;
	logic [CMP_W-1:0]       sum_ext;
	logic [CMP_W-1:0]       lo_ext;
	logic [CMP_W-1:0]       hi_ext;
	logic [LENGTH_BITS-1:0] rd_masked;
	logic [LENGTH_BITS-1:0] inc;

	// window bounds clipped to the alphabet
	always_comb begin
		letter_ext = CMP_W'(letter);
		gap_ext    = CMP_W'(gap_q);
		sum_ext    = letter_ext + gap_ext;
		lo_ext     = (letter_ext > gap_ext) ? (letter_ext - gap_ext) : '0;
		hi_ext     = (sum_ext > LAST_IDX) ? LAST_IDX : sum_ext;
	end

	assign status.in_range  = (letter_ext <= LAST_IDX);
	assign status.scan_last = (addr_q == hi_q);

	// entries never written since a clear read as zero
	assign rd_masked = rd_ok_s1 ? rd_data_s1 : '0;

	// saturating increment of the window peak
	assign inc = (peak_q == '1) ? peak_q : (peak_q + LENGTH_BITS'(1));

	// gap register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (cfg_we) begin
			gap_q <= cfg_gap;
		end
	end

	// per-entry valid bits, cleared by reset or a start item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.accept && start_new) begin
			valid_q <= '0;
		end else if (cmd.write_back) begin
			valid_q[letter_q] <= 1'b1;
		end
	end

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write_back) begin
			mem_q[letter_q] <= inc;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem_q[addr_q];
		rd_ok_s1   <= valid_q[addr_q];
	end

	// read pending flag follows each issued address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.scan_issue;
		end
	end

	// scan pointer, window end and latched letter
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			letter_q <= letter_ext[IDX_W-1:0];
			addr_q   <= lo_ext[IDX_W-1:0];
			hi_q     <= hi_ext[IDX_W-1:0];
		end else if (cmd.scan_issue) begin
			addr_q <= addr_q + IDX_W'(1);
		end
	end

	// running peak over the window
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			peak_q <= '0;
		end else if (rd_pend_s1 && (rd_masked > peak_q)) begin
			peak_q <= rd_masked;
		end
	end

	// best length since the last start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (cmd.accept && start_new) begin
			best_q <= '0;
		end else if (cmd.write_back && (inc > best_q)) begin
			best_q <= inc;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= OUT_W'(best_q);
		end
	end

	assign best_length = out_q;

endmodule

FILE: hw/rtl/lis_ctrl.sv
// controller state machine and output valid flag
module lis_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  lis_pkg::lis_status_t status,
	output lis_pkg::lis_cmd_t    cmd
);
	import lis_pkg::*;

	lis_state_t state_q;
	lis_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.in_range ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// commands and handshake outputs
	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		cmd.accept     = (state_q == ST_IDLE) && in_valid;
		cmd.scan_issue = (state_q == ST_SCAN);
		cmd.write_back = (state_q == ST_WRITE);
		cmd.load_out   = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// a result never overwrites one still held by the receiver
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a stalled item");

	// the drain cycle always leads to the write-back
	a_drain_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_WRITE))
		else $error("drain not followed by write-back");

	// an out-of-range letter skips the scan
	a_skip_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !status.in_range) |=> (state_q == ST_DONE))
		else $error("out-of-range letter entered the scan");

	// write-back only after the last read has been folded in
	a_write_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_back |-> ($past(state_q) == ST_DRAIN))
		else $error("write-back without drain");

endmodule

FILE: hw/rtl/longest_ideal_subsequence_length.sv
// Longest ideal subsequence length: per item (letter, start_new) the block scans the table
// entries inside the window clip(letter - max_gap .. letter + max_gap) through the table's
// single read port, one entry per cycle, then writes back the saturated peak plus one and
// updates the best length. An in-alphabet letter passes through the scan, drain, write and done
// states, the clipped window holding 1 to ALPHABET_SIZE entries, before the next item can be
// taken, and stays in done while the result register is still held; a letter outside the
// alphabet goes straight to done. start_new clears the table and the best value at once through
// per-entry valid bits. max_gap is written through the cfg channel, which is always ready.
module longest_ideal_subsequence_length #(
	parameter int ALPHABET_SIZE = 26,
	parameter int LENGTH_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lis_pkg::GAP_W-1:0]    max_gap,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lis_pkg::LETTER_W-1:0] letter,
	input  logic                         start_new,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lis_pkg::OUT_W-1:0]    best_length
);
	import lis_pkg::*;

	lis_cmd_t    cmd;
	lis_status_t status;

	assign cfg_ready = 1'b1;

	// controller
	lis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	lis_datapath #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.letter      (letter),
		.start_new   (start_new),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_gap     (max_gap),
		.best_length (best_length)
	);

endmodule

FILE: test/best_length_checker.sv
`timescale 1ns / 1ps
// scoreboard for the longest ideal subsequence block: predicts best_length and checks results
module best_length_checker #(
	parameter int ALPHABET_SIZE = 26,
	parameter int LENGTH_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [lis_pkg::GAP_W-1:0]    max_gap,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [lis_pkg::LETTER_W-1:0] letter,
	input  logic                         start_new,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [lis_pkg::OUT_W-1:0]    best_length,
	output int                           fail_count,
	output int                           pending_count,
	output int                           result_count
);
	import lis_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	// per-letter run lengths, best value and the gap register as the block should hold them
	logic [LENGTH_BITS-1:0] run_len [ALPHABET_SIZE];
	logic [LENGTH_BITS-1:0] best_len;
	logic [GAP_W-1:0]       gap_setting;
	logic [OUT_W-1:0]       expected_lengths [$];

	// fold one letter into the table and return the length the block should report
	function automatic logic [OUT_W-1:0] predict_best_length(input logic [LETTER_W-1:0] l,
			input logic restart);
		int lo;
		int hi;
		int j;
		logic [LENGTH_BITS-1:0] peak;
		if (restart) begin
			foreach (run_len[i]) run_len[i] = '0;
			best_len = '0;
		end
		// letters outside the alphabet leave the table alone
		if (int'(l) < ALPHABET_SIZE) begin
			lo = int'(l) - int'(gap_setting);
			if (lo < 0) lo = 0;
			hi = int'(l) + int'(gap_setting);
			if (hi > ALPHABET_SIZE - 1) hi = ALPHABET_SIZE - 1;
			peak = '0;
			for (j = lo; j <= hi; j++) begin
				if (run_len[j] > peak) peak = run_len[j];
			end
			// saturate at the counter maximum
			if (peak != LEN_MAX) peak = peak + 1'b1;
			run_len[l] = peak;
			if (peak > best_len) best_len = peak;
		end
		return OUT_W'(best_len);
	endfunction

	// watch the three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		logic [OUT_W-1:0] want;
		logic [OUT_W-1:0] next_want;
		if (!arst_n) begin
			foreach (run_len[i]) run_len[i] = '0;
			best_len = '0;
			gap_setting = '0;
			expected_lengths.delete();
			fail_count = 0;
			pending_count = 0;
			result_count = 0;
		end else begin
			// results first: they belong to items taken on earlier edges
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_lengths.size() == 0) begin
					fail_count++;
					$display("%0t unexpected result: expected none, actual %0d", $time,
						best_length);
				end else begin
					want = expected_lengths.pop_front();
					if (best_length !== want) begin
						fail_count++;
						$display("%0t best_length mismatch: expected %0d, actual %0d", $time,
							want, best_length);
					end
				end
			end
			if (in_valid && !in_stall) begin
				next_want = predict_best_length(letter, start_new);
				expected_lengths.insert(expected_lengths.size(), next_want);
			end
			if (cfg_valid && cfg_ready)
				gap_setting = max_gap;
			pending_count = expected_lengths.size();
		end
	end

endmodule

FILE: test/tb_longest_ideal_subsequence_length.sv
`timescale 1ns / 1ps
// testbench top: drives letters and max_gap, paces the result side and reports the verdict
module tb_longest_ideal_subsequence_length;
	import lis_pkg::*;

	localparam int ALPHABET_SIZE = 26;
	localparam int LENGTH_BITS   = 16;
	localparam int SEG_ITEMS     = 125;
	localparam int REPEAT_RUN    = 20;
	localparam int HOLD_CYCLES   = 200;
	localparam int LETTER_TOP    = (1 << LETTER_W) - 1;

	typedef enum {
		PRESS_NONE,
		PRESS_HOLD_OUTPUT,
		PRESS_DRAIN_INPUT
	} press_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [GAP_W-1:0]    max_gap;
	logic                in_valid;
	logic                in_stall;
	logic [LETTER_W-1:0] letter;
	logic                start_new;
	logic                out_valid;
	logic                out_stall;
	logic [OUT_W-1:0]    best_length;

	int                  fail_count;
	int                  pending_count;
	int                  result_count;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	logic                hold_request = 1'b0;
	logic [GAP_W-1:0]    gap_now = '0;
	int                  items_sent = 0;
	int                  outside_count = 0;
	int                  restart_count = 0;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	longest_ideal_subsequence_length #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.LENGTH_BITS(LENGTH_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_gap(max_gap),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.letter(letter),
		.start_new(start_new),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.best_length(best_length)
	);

	best_length_checker #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.LENGTH_BITS(LENGTH_BITS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_gap(max_gap),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.letter(letter),
		.start_new(start_new),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.best_length(best_length),
		.fail_count(fail_count),
		.pending_count(pending_count),
		.result_count(result_count)
	);

	// result side: random stall, or a long hold-off when one is requested
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// offer one item, with random idle cycles ahead of it, and wait until it is taken
	task automatic send_item(input logic [LETTER_W-1:0] l, input logic restart);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		letter = l;
		start_new = restart;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
		if (int'(l) >= ALPHABET_SIZE) outside_count++;
		if (restart) restart_count++;
	endtask

	// stop offering and wait until every expected result has come back
	task automatic drain_results();
		in_valid = 1'b0;
		while (pending_count != 0) @(negedge clk);
	endtask

	// write max_gap through the config channel
	task automatic write_gap(input logic [GAP_W-1:0] g);
		cfg_valid = 1'b1;
		max_gap = g;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		gap_now = g;
	endtask

	// random letter: often near the previous one so runs grow, a few outside the alphabet
	function automatic logic [LETTER_W-1:0] pick_letter(input logic [LETTER_W-1:0] prev);
		int g;
		int l;
		if ($urandom_range(0, 99) < 5)
			return LETTER_W'($urandom_range(ALPHABET_SIZE, LETTER_TOP));
		g = (int'(gap_now) > ALPHABET_SIZE - 1) ? ALPHABET_SIZE - 1 : int'(gap_now);
		if ($urandom_range(0, 99) < 45 && int'(prev) < ALPHABET_SIZE) begin
			l = int'(prev) - g + int'($urandom_range(0, 2 * g));
			if (l < 0) l = 0;
			if (l > ALPHABET_SIZE - 1) l = ALPHABET_SIZE - 1;
		end else begin
			l = $urandom_range(0, ALPHABET_SIZE - 1);
		end
		return LETTER_W'(l);
	endfunction

	// one random segment at a fixed gap setting
	task automatic run_segment(input logic [GAP_W-1:0] g, input int n, input press_t press);
		logic [LETTER_W-1:0] l;
		int k;
		drain_results();
		write_gap(g);
		l = '0;
		for (k = 0; k < n; k++) begin
			if (press == PRESS_HOLD_OUTPUT && k == 30) hold_request = 1'b1;
			if (press == PRESS_DRAIN_INPUT && k == 60) drain_results();
			l = pick_letter(l);
			send_item(l, $urandom_range(0, 99) < 2);
		end
	endtask

	// stimulus and verdict
	initial begin : stimulus
		logic [GAP_W-1:0] seg_gaps [6];
		int s;
		press_t press;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		max_gap = '0;
		in_valid = 1'b0;
		letter = '0;
		start_new = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: gap 0, both alphabet ends, letters outside the alphabet
		write_gap(GAP_W'(0));
		send_item(LETTER_W'(0), 1'b1);
		send_item(LETTER_W'(0), 1'b0);
		send_item(LETTER_W'(25), 1'b0);
		send_item(LETTER_W'(LETTER_TOP), 1'b0);
		send_item(LETTER_W'(26), 1'b0);
		send_item(LETTER_W'(1), 1'b0);
		// directed: wide gap past the alphabet, restart on an ignored letter
		drain_results();
		write_gap(GAP_W'(31));
		send_item(LETTER_W'(13), 1'b0);
		send_item(LETTER_W'(0), 1'b0);
		send_item(LETTER_W'(25), 1'b0);
		send_item(LETTER_W'(30), 1'b1);
		send_item(LETTER_W'(12), 1'b0);
		// directed: gap that just spans the alphabet
		drain_results();
		write_gap(GAP_W'(25));
		send_item(LETTER_W'(0), 1'b1);
		send_item(LETTER_W'(25), 1'b0);
		send_item(LETTER_W'(24), 1'b0);
		send_item(LETTER_W'(1), 1'b0);
		// directed: gap 1, neighbours in and out of the window
		drain_results();
		write_gap(GAP_W'(1));
		send_item(LETTER_W'(5), 1'b1);
		send_item(LETTER_W'(6), 1'b0);
		send_item(LETTER_W'(8), 1'b0);
		send_item(LETTER_W'(7), 1'b0);
		send_item(LETTER_W'(21), 1'b1);
		send_item(LETTER_W'(16), 1'b0);

		// random segments over several gap settings and idle patterns
		seg_gaps[0] = GAP_W'(0);
		seg_gaps[1] = GAP_W'(25);
		seg_gaps[2] = GAP_W'(31);
		seg_gaps[3] = GAP_W'($urandom_range(0, 31));
		seg_gaps[4] = GAP_W'(1);
		seg_gaps[5] = GAP_W'($urandom_range(2, 24));
		for (s = 0; s < 6; s++) begin
			unique case (s / 2)
				0: begin
					send_idle_pct = 22;
					recv_stall_pct = 50;
				end
				1: begin
					send_idle_pct = 50;
					recv_stall_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			press = (s == 4) ? PRESS_HOLD_OUTPUT : (s == 5) ? PRESS_DRAIN_INPUT : PRESS_NONE;
			run_segment(seg_gaps[s], SEG_ITEMS, press);
		end

		// one letter repeated so its run length keeps growing
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain_results();
		write_gap(GAP_W'(0));
		send_item(LETTER_W'(7), 1'b1);
		repeat (REPEAT_RUN) send_item(LETTER_W'(7), 1'b0);
		send_item(LETTER_W'(8), 1'b0);
		drain_results();
		write_gap(GAP_W'(1));
		send_item(LETTER_W'(8), 1'b0);
		send_item(LETTER_W'(6), 1'b0);

		drain_results();
		repeat (64) @(negedge clk);
		$display("run covered %0d letters (%0d outside the alphabet, %0d restarts), %0d results",
			items_sent, outside_count, restart_count, result_count);
		$display("max_gap from 0 to 31, long output hold-off, input drain, repeated-letter run");
		if (fail_count == 0 && pending_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
